### hdl/acd_pkg.sv
// Shared types and character constants for the ASCII command decoder.
package acd_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned SwitchW  = 4;
  localparam int unsigned LedW     = 4;
  localparam int unsigned AccW     = 14;
  localparam int unsigned DutyW    = 10;
  localparam int unsigned CountW   = 3;

  localparam logic [DutyW-1:0] MaxDutyReset = DutyW'(100);

  localparam logic [CharW-1:0] ChAmp   = 8'h26;
  localparam logic [CharW-1:0] ChL     = 8'h4C;
  localparam logic [CharW-1:0] ChS     = 8'h53;
  localparam logic [CharW-1:0] ChB     = 8'h42;
  localparam logic [CharW-1:0] ChC     = 8'h43;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  localparam logic [CountW-1:0] BuzzDigits = CountW'(4);
  localparam logic [CountW-1:0] FanDigits  = CountW'(3);

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhLedAct = 3'd1,
    PhLedNum = 3'd2,
    PhSwNum  = 3'd3,
    PhBuzz   = 3'd4,
    PhFan    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    RpNone = 2'd0,
    RpAck  = 2'd1,
    RpErr  = 2'd2
  } reply_e;

  typedef struct packed {
    logic [CharW-1:0]   rx_char;
    logic [SwitchW-1:0] switch_levels;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       reply_code;
    logic             switch_report_valid;
    logic             switch_closed;
    logic [LedW-1:0]  led_drive;
    logic             buzzer_start;
    logic [AccW-1:0]  buzzer_duration_ms;
    logic             fan_update;
    logic [DutyW-1:0] fan_duty;
  } out_word_t;

endpackage

### hdl/acd_parser.sv
// Command parser: phase state, LED bits, digit accumulator and the result logic.
module acd_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  acd_pkg::in_word_t               word_i,
  input  logic [acd_pkg::DutyW-1:0]       max_duty_i,
  output acd_pkg::out_word_t              result_o
);
  import acd_pkg::*;

  phase_e              phase_q, phase_d;
  logic                target_q, target_d;
  logic [LedW-1:0]     led_q, led_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [AccW-1:0]     acc_q, acd_acc_d;

  logic                is_digit;
  logic [3:0]          digit;
  logic                is_sel;
  logic [1:0]          sel;
  logic [AccW-1:0]     acc_next;
  logic [CountW-1:0]   count_next;
  logic                is_amp;

  assign is_amp     = (word_i.rx_char == ChAmp);
  assign is_digit   = (word_i.rx_char >= ChZero) && (word_i.rx_char <= ChNine);
  assign digit      = is_digit ? 4'(word_i.rx_char - ChZero) : 4'd0;
  assign is_sel     = is_digit && (digit >= 4'd1) && (digit <= 4'd4);
  assign sel        = 2'(digit - 4'd1);
  assign acc_next   = AccW'((acc_q << 3) + (acc_q << 1) + AccW'(digit));
  assign count_next = CountW'(count_q + CountW'(1));

  always_comb begin
    phase_d = phase_q;
    if (is_amp) begin
      phase_d = PhIdle;
    end else begin
      case (phase_q)
        PhIdle: begin
          if (word_i.rx_char == ChL) begin
            phase_d = PhLedAct;
          end else if (word_i.rx_char == ChS) begin
            phase_d = PhSwNum;
          end else if (word_i.rx_char == ChB) begin
            phase_d = PhBuzz;
          end else if (word_i.rx_char == ChC) begin
            phase_d = PhFan;
          end
        end
        PhLedAct: begin
          if ((word_i.rx_char == ChC) || (word_i.rx_char == ChS)) begin
            phase_d = PhLedNum;
          end else begin
            phase_d = PhIdle;
          end
        end
        PhBuzz: begin
          if (!is_digit || (count_next == BuzzDigits)) begin
            phase_d = PhIdle;
          end
        end
        PhFan: begin
          if (!is_digit || (count_next == FanDigits)) begin
            phase_d = PhIdle;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_comb begin
    target_d  = target_q;
    led_d     = led_q;
    count_d   = count_q;
    acd_acc_d = acc_q;
    result_o  = '0;
    if (!is_amp) begin
      case (phase_q)
        PhIdle: begin
          if ((word_i.rx_char == ChB) || (word_i.rx_char == ChC)) begin
            count_d   = '0;
            acd_acc_d = '0;
          end else if ((word_i.rx_char != ChL) && (word_i.rx_char != ChS)) begin
            result_o.reply_code = RpErr;
          end
        end
        PhLedAct: begin
          if (word_i.rx_char == ChC) begin
            target_d = 1'b0;
          end else if (word_i.rx_char == ChS) begin
            target_d = 1'b1;
          end else begin
            result_o.reply_code = RpErr;
          end
        end
        PhLedNum: begin
          if (is_sel) begin
            result_o.reply_code = RpAck;
            led_d[sel] = target_q;
          end else begin
            result_o.reply_code = RpErr;
          end
        end
        PhSwNum: begin
          if (is_sel) begin
            result_o.reply_code          = RpAck;
            result_o.switch_report_valid = 1'b1;
            result_o.switch_closed       = word_i.switch_levels[sel];
          end else begin
            result_o.reply_code = RpErr;
          end
        end
        PhBuzz: begin
          if (is_digit) begin
            acd_acc_d = acc_next;
            count_d   = count_next;
            if (count_next == BuzzDigits) begin
              result_o.reply_code         = RpAck;
              result_o.buzzer_start       = 1'b1;
              result_o.buzzer_duration_ms = acc_next;
            end
          end else begin
            result_o.reply_code = RpErr;
          end
        end
        PhFan: begin
          if (is_digit) begin
            acd_acc_d = acc_next;
            count_d   = count_next;
            if (count_next == FanDigits) begin
              if (acc_next <= AccW'(max_duty_i)) begin
                result_o.reply_code = RpAck;
                result_o.fan_update = 1'b1;
                result_o.fan_duty   = acc_next[DutyW-1:0];
              end else begin
                result_o.reply_code = RpErr;
              end
            end
          end else begin
            result_o.reply_code = RpErr;
          end
        end
        default: begin
          result_o.reply_code = RpErr;
        end
      endcase
    end
    result_o.led_drive = led_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      target_q <= 1'b0;
      led_q    <= '0;
      count_q  <= '0;
      acc_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      target_q <= target_d;
      led_q    <= led_d;
      count_q  <= count_d;
      acc_q    <= acd_acc_d;
    end
  end

endmodule

### hdl/ascii_command_decoder.sv
// Top level of the ASCII command decoder: input register, parser and result register.
// A word accepted into the input register is parsed combinationally; its result is captured in the result register.
// Throughput: one word per cycle while results are not stalled; the parser settles each character combinationally.
// A stalled result holds the input register, which then backs up the input channel.
// Reset (asynchronous, active low) empties both registers, returns the parser to idle,
// turns all LEDs off and loads the maximum fan duty with 100.
module ascii_command_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  acd_pkg::in_word_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output acd_pkg::out_word_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [acd_pkg::DutyW-1:0]   cfg_data_i
);
  import acd_pkg::*;

  logic             in_valid_q;
  in_word_t         in_data_q;
  logic             out_valid_q;
  out_word_t        out_data_q;
  logic [DutyW-1:0] max_duty_q;
  logic             advance;
  out_word_t        result;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  acd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .word_i     (in_data_q),
    .max_duty_i (max_duty_q),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      max_duty_q  <= MaxDutyReset;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        max_duty_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

endmodule

### hdl/acd_checker.sv
// Port-level checker for the ASCII command decoder and its bind to the top level.
module acd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input acd_pkg::out_word_t        out_data_o
);
  import acd_pkg::*;

  // A held result keeps its valid and its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // The input side only stalls when a result is waiting and not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  // Buzzer, fan and switch report events are always acknowledged and carry data only with their flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.buzzer_start || out_data_o.fan_update ||
                    out_data_o.switch_report_valid) |-> out_data_o.reply_code == RpAck)
    else $error("event without acknowledge");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.buzzer_start || out_data_o.buzzer_duration_ms == '0) &&
                    (out_data_o.fan_update || out_data_o.fan_duty == '0) &&
                    (out_data_o.switch_report_valid || !out_data_o.switch_closed))
    else $error("event data present without its flag");

endmodule

bind ascii_command_decoder acd_checker u_acd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### dv/tb_top.sv
// Testbench for the ASCII command decoder: directed and random command streams checked word by word.
`timescale 1ns / 1ps

module tb_top;
  import acd_pkg::*;

  typedef struct {
    logic      pinned;
    out_word_t want;
  } pin_t;

  typedef struct {
    in_word_t  word;
    logic      pinned;
    out_word_t want;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_word_t         in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_word_t        out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [DutyW-1:0] cfg_data_i;

  phase_e            parse_st;
  logic              led_pending;
  logic [LedW-1:0]   led_state;
  logic [CountW-1:0] digits_seen;
  logic [AccW-1:0]   acc_val;
  logic [DutyW-1:0]  duty_limit;

  out_word_t due_replies_q[$];
  pin_t      table_pins_q[$];
  dir_row_t  dir_rows[$];

  int gap_pct;
  int stall_pct;
  bit calm;
  int sent_cnt;
  int result_cnt;
  int ack_cnt;
  int nak_cnt;
  int buzz_cnt;
  int fan_cnt;
  int bad_cnt;

  ascii_command_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timeout: the run did not finish in time.");
    $display("*** FAILED ***");
    $finish;
  end

  function automatic out_word_t mk_out(reply_e rc, logic swv, logic swc, logic [LedW-1:0] led,
                                       logic bz, logic [AccW-1:0] dur, logic fu,
                                       logic [DutyW-1:0] duty);
    out_word_t w;
    w.reply_code          = rc;
    w.switch_report_valid = swv;
    w.switch_closed       = swc;
    w.led_drive           = led;
    w.buzzer_start        = bz;
    w.buzzer_duration_ms  = dur;
    w.fan_update          = fu;
    w.fan_duty            = duty;
    return w;
  endfunction

  function automatic out_word_t parse_char(in_word_t w);
    out_word_t  r;
    logic       dig;
    logic       sel;
    logic [3:0] d;
    r   = '0;
    dig = (w.rx_char >= ChZero) && (w.rx_char <= ChNine);
    d   = dig ? 4'(w.rx_char - ChZero) : 4'd0;
    sel = dig && (d >= 4'd1) && (d <= 4'd4);
    r.reply_code = RpNone;
    if (w.rx_char == ChAmp) begin
      parse_st = PhIdle;
    end else begin
      case (parse_st)
        PhIdle: begin
          if (w.rx_char == ChL) begin
            parse_st = PhLedAct;
          end else if (w.rx_char == ChS) begin
            parse_st = PhSwNum;
          end else if (w.rx_char == ChB || w.rx_char == ChC) begin
            parse_st    = (w.rx_char == ChB) ? PhBuzz : PhFan;
            digits_seen = '0;
            acc_val     = '0;
          end else begin
            r.reply_code = RpErr;
          end
        end
        PhLedAct: begin
          if (w.rx_char == ChC || w.rx_char == ChS) begin
            led_pending = (w.rx_char == ChS);
            parse_st    = PhLedNum;
          end else begin
            r.reply_code = RpErr;
            parse_st     = PhIdle;
          end
        end
        PhLedNum: begin
          parse_st = PhIdle;
          if (sel) begin
            r.reply_code       = RpAck;
            led_state[d - 1] = led_pending;
          end else begin
            r.reply_code = RpErr;
          end
        end
        PhSwNum: begin
          parse_st = PhIdle;
          if (sel) begin
            r.reply_code          = RpAck;
            r.switch_report_valid = 1'b1;
            r.switch_closed       = w.switch_levels[d - 1];
          end else begin
            r.reply_code = RpErr;
          end
        end
        PhBuzz, PhFan: begin
          if (dig) begin
            acc_val     = AccW'(int'(acc_val) * 10 + int'(d));
            digits_seen = digits_seen + 1'b1;
            if (parse_st == PhBuzz && digits_seen == BuzzDigits) begin
              r.reply_code         = RpAck;
              r.buzzer_start       = 1'b1;
              r.buzzer_duration_ms = acc_val;
              parse_st             = PhIdle;
            end else if (parse_st == PhFan && digits_seen == FanDigits) begin
              if (acc_val <= AccW'(duty_limit)) begin
                r.reply_code = RpAck;
                r.fan_update = 1'b1;
                r.fan_duty   = DutyW'(acc_val);
              end else begin
                r.reply_code = RpErr;
              end
              parse_st = PhIdle;
            end
          end else begin
            r.reply_code = RpErr;
            parse_st     = PhIdle;
          end
        end
        default: begin
          r.reply_code = RpErr;
          parse_st     = PhIdle;
        end
      endcase
    end
    r.led_drive = led_state;
    return r;
  endfunction

  task automatic log_mismatch(string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    bad_cnt++;
  endtask

  task automatic cmp_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    pin_t      tag;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_replies_q.size() == 0) begin
          log_mismatch($sformatf("result word %h with nothing expected", out_data_o));
        end else begin
          want = due_replies_q.pop_front();
          result_cnt++;
          if (want.reply_code == RpAck) ack_cnt++;
          if (want.reply_code == RpErr) nak_cnt++;
          if (want.buzzer_start) buzz_cnt++;
          if (want.fan_update) fan_cnt++;
          cmp_field("reply_code", out_data_o.reply_code, want.reply_code);
          cmp_field("switch_report_valid", out_data_o.switch_report_valid,
                    want.switch_report_valid);
          cmp_field("switch_closed", out_data_o.switch_closed, want.switch_closed);
          cmp_field("led_drive", out_data_o.led_drive, want.led_drive);
          cmp_field("buzzer_start", out_data_o.buzzer_start, want.buzzer_start);
          cmp_field("buzzer_duration_ms", out_data_o.buzzer_duration_ms,
                    want.buzzer_duration_ms);
          cmp_field("fan_update", out_data_o.fan_update, want.fan_update);
          cmp_field("fan_duty", out_data_o.fan_duty, want.fan_duty);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        duty_limit = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        tag = '{pinned: 1'b0, want: '0};
        if (table_pins_q.size() != 0) tag = table_pins_q.pop_front();
        want = parse_char(in_data_i);
        due_replies_q.push_back(tag.pinned ? tag.want : want);
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(99) < stall_pct) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(7, 1) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
        repeat ($urandom_range(12, 1) - 1) @(negedge clk_i);
      end
    end
  end

  task automatic send_item(in_word_t w, logic pin, out_word_t want);
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < gap_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(7, 1)) @(negedge clk_i);
    end
    table_pins_q.push_back('{pinned: pin, want: want});
    in_valid_i = 1'b1;
    in_data_i  = w;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
  endtask

  task automatic put_char(logic [CharW-1:0] ch);
    in_word_t w;
    w.rx_char       = ch;
    w.switch_levels = SwitchW'($urandom_range(15));
    send_item(w, 1'b0, '0);
  endtask

  task automatic add_row(logic [CharW-1:0] ch, logic [SwitchW-1:0] sw, logic pin,
                         out_word_t want);
    dir_row_t row;
    row.word.rx_char       = ch;
    row.word.switch_levels = sw;
    row.pinned             = pin;
    row.want               = want;
    dir_rows.push_back(row);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (due_replies_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CharW-1:0] any_char();
    return CharW'($urandom_range(255));
  endfunction

  function automatic logic [CharW-1:0] sel_digit();
    int r;
    r = $urandom_range(9);
    if (r < 7) return ChZero + CharW'($urandom_range(4, 1));
    if (r < 9) return ChZero + CharW'($urandom_range(9));
    return any_char();
  endfunction

  task automatic send_number(int num, int n);
    int scale;
    scale = 1;
    repeat (n - 1) scale *= 10;
    repeat (n) begin
      if ($urandom_range(39) == 0) put_char(any_char());
      else put_char(ChZero + CharW'((num / scale) % 10));
      scale /= 10;
    end
  endtask

  initial begin
    logic [DutyW-1:0] duty_plan [5];
    int               gap_plan [5];
    int               stall_plan [5];
    logic [CharW-1:0] lead [4];
    int               pick;
    int               v;
    int               num;
    int               stop_at;
    bit               paused;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    gap_pct     = 0;
    stall_pct   = 0;
    calm        = 1'b0;
    paused      = 1'b0;
    parse_st    = PhIdle;
    led_pending = 1'b0;
    led_state   = '0;
    digits_seen = '0;
    acc_val     = '0;
    duty_limit  = MaxDutyReset;
    lead        = '{ChL, ChS, ChB, ChC};

    add_row(8'hFF, 4'h0, 1'b1, mk_out(RpErr, 0, 0, 4'h0, 0, 0, 0, 0));
    add_row(8'h00, 4'hF, 1'b1, mk_out(RpErr, 0, 0, 4'h0, 0, 0, 0, 0));
    add_row(ChL, 4'h0, 1'b1, mk_out(RpNone, 0, 0, 4'h0, 0, 0, 0, 0));
    add_row(ChS, 4'h0, 1'b1, mk_out(RpNone, 0, 0, 4'h0, 0, 0, 0, 0));
    add_row(ChZero + 8'd4, 4'h0, 1'b1, mk_out(RpAck, 0, 0, 4'h8, 0, 0, 0, 0));
    add_row(ChL, 4'h0, 1'b1, mk_out(RpNone, 0, 0, 4'h8, 0, 0, 0, 0));
    add_row(ChC, 4'h0, 1'b1, mk_out(RpNone, 0, 0, 4'h8, 0, 0, 0, 0));
    add_row(ChZero + 8'd4, 4'h0, 1'b1, mk_out(RpAck, 0, 0, 4'h0, 0, 0, 0, 0));
    add_row(ChL, 4'h0, 1'b1, mk_out(RpNone, 0, 0, 4'h0, 0, 0, 0, 0));
    add_row("Q", 4'h0, 1'b1, mk_out(RpErr, 0, 0, 4'h0, 0, 0, 0, 0));
    add_row(ChL, 4'h0, 1'b0, '0);
    add_row(ChS, 4'h0, 1'b0, '0);
    add_row(ChZero, 4'h0, 1'b1, mk_out(RpErr, 0, 0, 4'h0, 0, 0, 0, 0));
    add_row(ChS, 4'hA, 1'b0, '0);
    add_row(ChZero + 8'd2, 4'hA, 1'b1, mk_out(RpAck, 1, 1, 4'h0, 0, 0, 0, 0));
    add_row(ChB, 4'h0, 1'b0, '0);
    add_row(ChNine, 4'h0, 1'b0, '0);
    add_row(ChNine, 4'h0, 1'b0, '0);
    add_row(ChNine, 4'h0, 1'b0, '0);
    add_row(ChNine, 4'h0, 1'b1, mk_out(RpAck, 0, 0, 4'h0, 1, 14'd9999, 0, 0));
    add_row(ChC, 4'h0, 1'b0, '0);
    add_row(ChZero + 8'd1, 4'h0, 1'b0, '0);
    add_row(ChZero, 4'h0, 1'b0, '0);
    add_row(ChZero + 8'd1, 4'h0, 1'b0, '0);
    add_row(ChC, 4'h0, 1'b0, '0);
    add_row(ChAmp, 4'h0, 1'b0, '0);

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].want);
    drain();

    duty_plan  = '{10'd999, 10'd0, DutyW'($urandom_range(998, 1)), MaxDutyReset,
                   DutyW'($urandom_range(999))};
    gap_plan   = '{25, 40, 10, 60, 0};
    stall_plan = '{25, 10, 50, 40, 0};

    for (int p = 0; p < 5; p++) begin
      @(negedge clk_i);
      cfg_valid_i = 1'b1;
      cfg_data_i  = duty_plan[p];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
      cfg_valid_i = 1'b0;
      gap_pct   = gap_plan[p];
      stall_pct = stall_plan[p];
      calm      = (p == 4);
      stop_at   = sent_cnt + 390;
      while (sent_cnt < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 18) begin
          put_char(ChL);
          v = $urandom_range(19);
          put_char(v == 0 ? any_char() : (v < 10 ? ChS : ChC));
          put_char(sel_digit());
        end else if (pick < 32) begin
          put_char(ChS);
          put_char(sel_digit());
        end else if (pick < 52) begin
          put_char(ChB);
          v = $urandom_range(9);
          send_number(v == 0 ? 0 : (v == 1 ? 9999 : int'($urandom_range(9999))), 4);
        end else if (pick < 77) begin
          put_char(ChC);
          v = $urandom_range(9);
          if (v < 4) begin
            num = int'(duty_limit) + int'($urandom_range(4)) - 2;
            if (num < 0) num = 0;
            if (num > 999) num = 999;
          end else if (v == 4) begin
            num = 999;
          end else if (v == 5) begin
            num = 0;
          end else begin
            num = $urandom_range(999);
          end
          send_number(num, 3);
        end else if (pick < 87) begin
          put_char(lead[$urandom_range(3)]);
          repeat ($urandom_range(2)) put_char(ChZero + CharW'($urandom_range(9)));
          put_char(ChAmp);
        end else begin
          repeat ($urandom_range(3, 1)) put_char(any_char());
        end
        // Hold the sender once, midway through the third phase, until every word in flight has come back.
        if (p == 2 && !paused && sent_cnt >= stop_at - 195) begin
          drain();
          paused = 1'b1;
        end
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (due_replies_q.size() != 0) begin
      log_mismatch($sformatf("%0d result words never arrived", due_replies_q.size()));
    end
    $display("Sent %0d command characters under 6 fan duty limits; checked %0d result words.",
             sent_cnt, result_cnt);
    $display("Seen %0d ACK and %0d ERR replies, %0d buzzer starts, %0d fan updates; %0d errors.",
             ack_cnt, nak_cnt, buzz_cnt, fan_cnt, bad_cnt);
    if (bad_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
hdl/acd_pkg.sv
hdl/acd_parser.sv
hdl/ascii_command_decoder.sv
hdl/acd_checker.sv
dv/tb_top.sv
